/* design/gbr_pkg.sv */
`timescale 1ns / 1ps

package gbr_pkg;

  // Screen geometry and glyph size limit.
  localparam int unsigned ScreenWidth  = 240;
  localparam int unsigned ScreenHeight = 320;
  localparam int unsigned MaxGlyphSize = 64;

  // Display controller command bytes.
  localparam logic [7:0] CMD_COL_WINDOW = 8'h2A;
  localparam logic [7:0] CMD_ROW_WINDOW = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

  // Input operation codes.
  localparam logic OP_START  = 1'b0;
  localparam logic OP_BITMAP = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_FG_COLOR     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BG_COLOR     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GLYPH_WIDTH  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GLYPH_HEIGHT = 3'd3;

  // Positions of the beats within the window header.
  localparam logic [3:0] HB_COL_CMD = 4'd0;
  localparam logic [3:0] HB_X1_HI   = 4'd1;
  localparam logic [3:0] HB_X1_LO   = 4'd2;
  localparam logic [3:0] HB_X2_HI   = 4'd3;
  localparam logic [3:0] HB_X2_LO   = 4'd4;
  localparam logic [3:0] HB_ROW_CMD = 4'd5;
  localparam logic [3:0] HB_Y1_HI   = 4'd6;
  localparam logic [3:0] HB_Y1_LO   = 4'd7;
  localparam logic [3:0] HB_Y2_HI   = 4'd8;
  localparam logic [3:0] HB_Y2_LO   = 4'd9;
  localparam logic [3:0] HB_MEM_CMD = 4'd10;

  // Controller to datapath.
  typedef struct packed {
    logic       accept;  // input beat taken this cycle
    logic       load;    // load the output register
    logic       hdr;     // header beat rather than pixel beat
    logic [3:0] beat;    // beat number within the item
    logic       last;    // final beat of the item
  } gbr_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       op;        // operation of the offered input beat
    logic       start_ok;  // offered start fits the screen
    logic       pix_go;    // offered bitmap byte yields pixels
    logic [3:0] used;      // captured pixel count of the current byte
    logic       out_free;  // output register can take a beat
  } gbr_sts_t;

endpackage

/* design/gbr_ctrl.sv */
`timescale 1ns / 1ps

module gbr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  gbr_pkg::gbr_sts_t sts_i,
  output gbr_pkg::gbr_cmd_t cmd_o
);
  import gbr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HDR  = 2'd1;
  localparam logic [1:0] ST_PIX  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [3:0] beat_q, beat_d;
  logic       accept;
  logic [3:0] last_beat;
  logic [4:0] pix_beats;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign pix_beats  = {sts_i.used, 1'b0} - 5'd1;
  assign last_beat  = (state_q == ST_HDR) ? HB_MEM_CMD : pix_beats[3:0];

  always_comb begin
    state_d = state_q;
    beat_d  = beat_q;
    cmd_o.accept = accept;
    cmd_o.load   = 1'b0;
    cmd_o.hdr    = (state_q == ST_HDR);
    cmd_o.beat   = beat_q;
    cmd_o.last   = (beat_q == last_beat);
    unique case (state_q) inside
      ST_IDLE: begin
        beat_d = 4'd0;
        if (accept) begin
          if (sts_i.op == OP_START && sts_i.start_ok) begin
            state_d = ST_HDR;
          end else if (sts_i.op == OP_BITMAP && sts_i.pix_go) begin
            state_d = ST_PIX;
          end
        end
      end
      ST_HDR, ST_PIX: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          if (beat_q == last_beat) begin
            state_d = ST_IDLE;
            beat_d  = 4'd0;
          end else begin
            beat_d = beat_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      beat_q  <= 4'd0;
    end else begin
      state_q <= state_d;
      beat_q  <= beat_d;
    end
  end

endmodule

/* design/gbr_dp.sv */
`timescale 1ns / 1ps

module gbr_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gbr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                 cfg_data_i,
  input  logic                        operation_i,
  input  logic [9:0]                  pos_x_i,
  input  logic [9:0]                  pos_y_i,
  input  logic [7:0]                  bitmap_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  link_byte_o,
  output logic                        is_command_o,
  output logic                        glyph_end_o,
  output logic                        last_o,
  input  gbr_pkg::gbr_cmd_t           cmd_i,
  output gbr_pkg::gbr_sts_t           sts_o
);
  import gbr_pkg::*;

  // Configuration registers.
  logic [15:0] fg_q, bg_q;
  logic [6:0]  width_q, height_q;

  // Glyph progress.
  logic       open_q, open_d;
  logic [5:0] row_q, row_d;
  logic [2:0] col_byte_q, col_byte_d;

  // Captured item.
  logic [9:0]  x1_q, y1_q;
  logic [10:0] x2_q, y2_q;
  logic [7:0]  bits_q;
  logic [3:0]  used_q;
  logic        done_q;

  // Output register.
  logic       out_valid_q;
  logic [7:0] byte_q;
  logic       cmd_flag_q, end_q, last_q;

  logic        w_ok, h_ok, start_ok;
  logic [10:0] x2, y2;
  logic [5:0]  start_bit;
  logic [6:0]  remain;
  logic [3:0]  used;
  logic [7:0]  wsum;
  logic [3:0]  row_bytes;
  logic        row_done, glyph_done;
  logic [2:0]  pix_idx;
  logic [15:0] colour;
  logic [7:0]  byte_d;
  logic        cmd_flag_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q     <= 16'hFFFF;
      bg_q     <= 16'h0000;
      width_q  <= 7'd8;
      height_q <= 7'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FG_COLOR:     fg_q     <= cfg_data_i;
        CFG_BG_COLOR:     bg_q     <= cfg_data_i;
        CFG_GLYPH_WIDTH:  width_q  <= cfg_data_i[6:0];
        CFG_GLYPH_HEIGHT: height_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Start check: size in range and the window inside the screen.
  assign w_ok = (width_q != 7'd0) && (width_q <= 7'(MaxGlyphSize));
  assign h_ok = (height_q != 7'd0) && (height_q <= 7'(MaxGlyphSize));
  assign x2   = {1'b0, pos_x_i} + {4'd0, width_q} - 11'd1;
  assign y2   = {1'b0, pos_y_i} + {4'd0, height_q} - 11'd1;
  assign start_ok = w_ok && h_ok && (x2 < 11'(ScreenWidth)) && (y2 < 11'(ScreenHeight));

  // Pixels used from the current byte, and where the row and glyph end.
  assign start_bit = {col_byte_q, 3'b000};
  assign remain    = width_q - {1'b0, start_bit};
  always_comb begin
    if ({1'b0, start_bit} < width_q) begin
      used = (remain > 7'd8) ? 4'd8 : remain[3:0];
    end else begin
      used = 4'd0;
    end
  end
  assign wsum       = {1'b0, width_q} + 8'd7;
  assign row_bytes  = wsum[6:3];
  assign row_done   = ({1'b0, col_byte_q} + 4'd1) >= row_bytes;
  assign glyph_done = row_done && (({1'b0, row_q} + 7'd1) >= height_q);

  always_comb begin
    open_d     = open_q;
    row_d      = row_q;
    col_byte_d = col_byte_q;
    if (operation_i == OP_START) begin
      open_d     = start_ok;
      row_d      = 6'd0;
      col_byte_d = 3'd0;
    end else if (open_q) begin
      if (!w_ok || !h_ok || glyph_done) begin
        open_d     = 1'b0;
        row_d      = 6'd0;
        col_byte_d = 3'd0;
      end else if (row_done) begin
        row_d      = row_q + 6'd1;
        col_byte_d = 3'd0;
      end else begin
        col_byte_d = col_byte_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      row_q      <= 6'd0;
      col_byte_q <= 3'd0;
    end else if (cmd_i.accept) begin
      open_q     <= open_d;
      row_q      <= row_d;
      col_byte_q <= col_byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x1_q   <= pos_x_i;
      y1_q   <= pos_y_i;
      x2_q   <= x2;
      y2_q   <= y2;
      bits_q <= bitmap_byte_i;
      used_q <= used;
      done_q <= glyph_done;
    end
  end

  // Beat formation.
  assign pix_idx = cmd_i.beat[3:1];
  assign colour  = bits_q[3'd7 - pix_idx] ? fg_q : bg_q;

  always_comb begin
    byte_d     = 8'h00;
    cmd_flag_d = 1'b0;
    if (cmd_i.hdr) begin
      unique case (cmd_i.beat)
        HB_COL_CMD: begin
          byte_d     = CMD_COL_WINDOW;
          cmd_flag_d = 1'b1;
        end
        HB_X1_HI:   byte_d = {6'd0, x1_q[9:8]};
        HB_X1_LO:   byte_d = x1_q[7:0];
        HB_X2_HI:   byte_d = {5'd0, x2_q[10:8]};
        HB_X2_LO:   byte_d = x2_q[7:0];
        HB_ROW_CMD: begin
          byte_d     = CMD_ROW_WINDOW;
          cmd_flag_d = 1'b1;
        end
        HB_Y1_HI:   byte_d = {6'd0, y1_q[9:8]};
        HB_Y1_LO:   byte_d = y1_q[7:0];
        HB_Y2_HI:   byte_d = {5'd0, y2_q[10:8]};
        HB_Y2_LO:   byte_d = y2_q[7:0];
        HB_MEM_CMD: begin
          byte_d     = CMD_MEM_WRITE;
          cmd_flag_d = 1'b1;
        end
        default: byte_d = 8'h00;
      endcase
    end else begin
      byte_d = cmd_i.beat[0] ? colour[7:0] : colour[15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q     <= byte_d;
      cmd_flag_q <= cmd_flag_d;
      end_q      <= !cmd_i.hdr && done_q && cmd_i.last;
      last_q     <= cmd_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign link_byte_o  = byte_q;
  assign is_command_o = cmd_flag_q;
  assign glyph_end_o  = end_q;
  assign last_o       = last_q;

  assign sts_o.op       = operation_i;
  assign sts_o.start_ok = start_ok;
  assign sts_o.pix_go   = open_q && w_ok && h_ok && (used != 4'd0);
  assign sts_o.used     = used_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

/* design/glyph_bitmap_to_rgb565_stream.sv */
`timescale 1ns / 1ps

// Channel | Handshake               | Payload
// --------+-------------------------+-------------------------------------------
// in      | in_valid_i, in_stall_o  | operation_i, pos_x_i, pos_y_i,
//         |                         | bitmap_byte_i
// out     | out_valid_o,out_stall_i | link_byte_o, is_command_o, glyph_end_o,
//         |                         | last_o
// cfg     | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_data_i
//
// A start beat that fits the screen expands to 11 header bytes, a bitmap beat
// to two bytes per pixel used. The input stalls until the last byte is in
// the single output register, which sends one byte per cycle unless
// stalled. Reset is asynchronous and active low: it restores the register
// defaults and closes any open glyph. A stall on the output holds the
// expansion; the next input beat is taken while the final byte still waits.

module glyph_bitmap_to_rgb565_stream (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [9:0]                  pos_x_i,
  input  logic [9:0]                  pos_y_i,
  input  logic [7:0]                  bitmap_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  link_byte_o,
  output logic                        is_command_o,
  output logic                        glyph_end_o,
  output logic                        last_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gbr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                 cfg_data_i
);
  import gbr_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  gbr_cmd_t cmd;
  gbr_sts_t sts;

  // The sequencer walks the header or the pixel beats of one item.
  gbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the registers, glyph progress and the output stage.
  gbr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .operation_i   (operation_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .bitmap_byte_i (bitmap_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .link_byte_o   (link_byte_o),
    .is_command_o  (is_command_o),
    .glyph_end_o   (glyph_end_o),
    .last_o        (last_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

/* verif/tb_glyph_bitmap_to_rgb565_stream.sv */
`timescale 1ns / 1ps

module tb_glyph_bitmap_to_rgb565_stream;
  import gbr_pkg::*;

  // Quiet cycles allowed after the last expected beat. The last input items
  // may cause no beat at all, yet each of those still has to be taken.
  localparam int SETTLE_CYCLES  = 20;
  // Cycles in a row with no beat on any channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;
  // A register index that names no register. Writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 3'd5;

  // How the expectation of a directed row is formed. Most rows go through
  // the shadow model; a few have their beats written out by hand.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,        // nothing may come out
    CHK_HDR_ORIGIN,  // window header of an 8 x 16 glyph at the origin
    CHK_ALL_FG       // one full byte of set pixels in white, not the last row
  } check_e;

  typedef struct packed {
    logic [7:0] data;
    logic       cmd;
    logic       gend;
    logic       last;
  } link_beat_t;

  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [15:0]        data;
    logic               op;
    logic [9:0]         px;
    logic [9:0]         py;
    logic [7:0]         bits;
    check_e             chk;
  } stim_row_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               operation     = 1'b0;
  logic [9:0]         pos_x         = '0;
  logic [9:0]         pos_y         = '0;
  logic [7:0]         bitmap_byte   = '0;
  logic               out_stall     = 1'b0;
  logic               cfg_valid     = 1'b0;
  logic [CfgIdxW-1:0] cfg_index     = '0;
  logic [15:0]        cfg_data      = '0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic [7:0]         link_byte_o;
  logic               is_command_o;
  logic               glyph_end_o;
  logic               last_o;
  logic               cfg_ready_o;

  wire in_beat  = in_valid && (in_stall_o === 1'b0);
  wire out_beat = (out_valid_o === 1'b1) && !out_stall;
  wire cfg_beat = cfg_valid && (cfg_ready_o === 1'b1);

  // Percentages of cycles in which the sender holds back and the receiver
  // stalls. They are changed between phases of the random part.
  int send_idle_pct = 13;
  int recv_idle_pct = 68;

  int fail_count   = 0;
  int quiet_cycles = 0;

  // Beats still owed by the block, oldest first.
  link_beat_t link_beats_q[$];
  stim_row_t  directed_q[$];

  // Shadow copy of the block: its registers and its glyph walk.
  logic [15:0] shadow_fg     = 16'hFFFF;
  logic [15:0] shadow_bg     = 16'h0000;
  logic [6:0]  shadow_width  = 7'd8;
  logic [6:0]  shadow_height = 7'd16;
  logic        shadow_open   = 1'b0;
  logic [5:0]  shadow_row    = '0;
  logic [2:0]  shadow_col    = '0;

  glyph_bitmap_to_rgb565_stream u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation),
    .pos_x_i       (pos_x),
    .pos_y_i       (pos_y),
    .bitmap_byte_i (bitmap_byte),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .link_byte_o   (link_byte_o),
    .is_command_o  (is_command_o),
    .glyph_end_o   (glyph_end_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #6 clk = ~clk;

  // The receiver decides afresh every cycle whether to stall.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Every beat that leaves the block is matched against the oldest one owed.
  always @(posedge clk) begin
    link_beat_t want;
    if (rst_n && out_beat) begin
      if (link_beats_q.size() == 0) begin
        $error("unexpected beat: link_byte %0h is_command %0b glyph_end %0b last %0b",
               link_byte_o, is_command_o, glyph_end_o, last_o);
        fail_count++;
      end else begin
        want = link_beats_q.pop_front();
        if (link_byte_o !== want.data) begin
          $error("link_byte: expected %0h, got %0h", want.data, link_byte_o);
          fail_count++;
        end
        if (is_command_o !== want.cmd) begin
          $error("is_command: expected %0b, got %0b", want.cmd, is_command_o);
          fail_count++;
        end
        if (glyph_end_o !== want.gend) begin
          $error("glyph_end: expected %0b, got %0b", want.gend, glyph_end_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // A run that stops moving is a failure in its own right.
  always @(posedge clk) begin
    if (!rst_n || in_beat || out_beat || cfg_beat) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic bit size_fits(input int unsigned s);
    return (s >= 1) && (s <= MaxGlyphSize);
  endfunction

  task automatic push_beat(input logic [7:0] data, input logic cmd, input logic gend,
                           input logic last);
    link_beat_t b;
    b.data = data;
    b.cmd  = cmd;
    b.gend = gend;
    b.last = last;
    link_beats_q.push_back(b);
  endtask

  // A window command is followed by its first and last coordinate, each sent
  // high byte first.
  task automatic push_window(input logic [7:0] cmd, input logic [15:0] lo_edge,
                             input logic [15:0] hi_edge);
    push_beat(cmd, 1'b1, 1'b0, 1'b0);
    push_beat(lo_edge[15:8], 1'b0, 1'b0, 1'b0);
    push_beat(lo_edge[7:0], 1'b0, 1'b0, 1'b0);
    push_beat(hi_edge[15:8], 1'b0, 1'b0, 1'b0);
    push_beat(hi_edge[7:0], 1'b0, 1'b0, 1'b0);
  endtask

  // Works out the beats that one accepted input item causes and moves the
  // shadow glyph walk on. The sizes in force at this moment apply, even in
  // the middle of a glyph.
  task automatic expand_glyph_item(input logic op, input logic [9:0] px,
                                   input logic [9:0] py, input logic [7:0] bits);
    int unsigned w, h, x2, y2, bpr, first, used, i;
    logic [15:0] colour;
    bit          fits, row_done, glyph_done, gend;
    w    = shadow_width;
    h    = shadow_height;
    fits = size_fits(w) && size_fits(h);
    if (op == OP_START) begin
      // A start always abandons whatever glyph was open.
      shadow_open = 1'b0;
      shadow_row  = '0;
      shadow_col  = '0;
      if (fits) begin
        x2 = px + w - 1;
        y2 = py + h - 1;
        if (x2 < ScreenWidth && y2 < ScreenHeight) begin
          push_window(CMD_COL_WINDOW, {6'd0, px}, 16'(x2));
          push_window(CMD_ROW_WINDOW, {6'd0, py}, 16'(y2));
          push_beat(CMD_MEM_WRITE, 1'b1, 1'b0, 1'b1);
          shadow_open = 1'b1;
        end
      end
    end else if (shadow_open) begin
      if (!fits) begin
        // A bad size seen by a bitmap byte shuts the glyph without output.
        shadow_open = 1'b0;
        shadow_row  = '0;
        shadow_col  = '0;
      end else begin
        bpr   = (w + 7) / 8;
        first = shadow_col * 8;
        used  = 0;
        if (first < w) begin
          used = w - first;
          if (used > 8) used = 8;
        end
        row_done   = (shadow_col + 1) >= bpr;
        glyph_done = row_done && ((shadow_row + 1) >= h);
        for (i = 0; i < used; i++) begin
          colour = bits[7 - i] ? shadow_fg : shadow_bg;
          gend   = glyph_done && (i + 1 == used);
          push_beat(colour[15:8], 1'b0, 1'b0, 1'b0);
          push_beat(colour[7:0], 1'b0, gend, (i + 1 == used));
        end
        if (glyph_done) begin
          shadow_open = 1'b0;
          shadow_row  = '0;
          shadow_col  = '0;
        end else if (row_done) begin
          shadow_row = shadow_row + 1'b1;
          shadow_col = '0;
        end else begin
          shadow_col = shadow_col + 1'b1;
        end
      end
    end
  endtask

  // Beats written out by hand for the directed rows that are easy to read.
  task automatic push_typed(input check_e chk);
    int i;
    case (chk)
      CHK_HDR_ORIGIN: begin
        push_beat(CMD_COL_WINDOW, 1'b1, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        push_beat(8'h07, 1'b0, 1'b0, 1'b0);
        push_beat(CMD_ROW_WINDOW, 1'b1, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        push_beat(8'h00, 1'b0, 1'b0, 1'b0);
        push_beat(8'h0F, 1'b0, 1'b0, 1'b0);
        push_beat(CMD_MEM_WRITE, 1'b1, 1'b0, 1'b1);
      end
      CHK_ALL_FG: begin
        for (i = 0; i < 16; i++) push_beat(8'hFF, 1'b0, 1'b0, (i == 15));
      end
      default: begin
      end
    endcase
  endtask

  // Offers one input beat, with a random hold-off first, and records what it
  // must cause once the block has taken it. Valid stays high on return so
  // that the next beat can follow without a gap.
  task automatic send_item(input logic op, input logic [9:0] px, input logic [9:0] py,
                           input logic [7:0] bits, input check_e chk);
    int owed;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    pos_x       <= px;
    pos_y       <= py;
    bitmap_byte <= bits;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    owed = link_beats_q.size();
    expand_glyph_item(op, px, py, bits);
    if (chk != CHK_MODEL) begin
      // The shadow state still moves on; only its beats are replaced.
      while (link_beats_q.size() > owed) void'(link_beats_q.pop_back());
      push_typed(chk);
    end
  endtask

  // Waits until the block has nothing left to send and has had time to
  // finish any item that sends nothing.
  task automatic drain_link();
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (link_beats_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_FG_COLOR:     shadow_fg     = data;
      CFG_BG_COLOR:     shadow_bg     = data;
      CFG_GLYPH_WIDTH:  shadow_width  = data[6:0];
      CFG_GLYPH_HEIGHT: shadow_height = data[6:0];
      default: begin
      end
    endcase
  endtask

  task automatic add_item(input logic op, input int px, input int py, input int bits,
                          input check_e chk);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = '0;
    r.data   = '0;
    r.op     = op;
    r.px     = 10'(px);
    r.py     = 10'(py);
    r.bits   = 8'(bits);
    r.chk    = chk;
    // Fields the operation does not use carry random values.
    if (op == OP_BITMAP) begin
      r.px = 10'($urandom);
      r.py = 10'($urandom);
    end else begin
      r.bits = 8'($urandom);
    end
    directed_q.push_back(r);
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    stim_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    r.chk    = CHK_MODEL;
    directed_q.push_back(r);
  endtask

  task automatic run_row(input stim_row_t r);
    if (r.is_cfg) begin
      drain_link();
      cfg_write(r.idx, r.data);
    end else begin
      send_item(r.op, r.px, r.py, r.bits, r.chk);
    end
  endtask

  function automatic logic [15:0] pick_colour();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 16'h0000;
    if (r < 30) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Size values are mostly small and legal, with the extremes and a few
  // illegal values mixed in.
  function automatic int unsigned pick_size(input bit is_height, input int unsigned w);
    int r;
    r = $urandom_range(99);
    if (!is_height && r < 8) return 64;
    if (is_height && r < 6 && w <= 8) return 64;
    if (r < 14) return 1;
    if (r < 18) return ($urandom_range(1) == 0) ? 0 : $urandom_range(127, 65);
    return is_height ? $urandom_range(4, 1) : $urandom_range(16, 1);
  endfunction

  // The upper data bits of a size register are ignored, so they are random.
  task automatic write_size(input logic [CfgIdxW-1:0] idx, input int unsigned s);
    logic [15:0] d;
    d      = 16'($urandom);
    d[6:0] = 7'(s);
    cfg_write(idx, d);
  endtask

  // One phase of random work under one setting of the registers. Most of it
  // is whole glyphs with random content; the rest is stray bytes, starts at
  // random places, glyphs cut short and sizes changed in mid-glyph.
  task automatic random_phase(input int target);
    int          n_items, r, nbytes, cut, b;
    int unsigned w, h;
    bit          fits;
    logic [9:0]  px, py;
    drain_link();
    cfg_write(CFG_FG_COLOR, pick_colour());
    cfg_write(CFG_BG_COLOR, pick_colour());
    w = pick_size(1'b0, 0);
    h = pick_size(1'b1, w);
    write_size(CFG_GLYPH_WIDTH, w);
    write_size(CFG_GLYPH_HEIGHT, h);
    n_items = 0;
    while (n_items < target) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_item(OP_BITMAP, 10'($urandom), 10'($urandom), 8'($urandom), CHK_MODEL);
        n_items++;
      end else if (r < 14) begin
        send_item(OP_START, 10'($urandom), 10'($urandom), 8'($urandom), CHK_MODEL);
        n_items++;
      end else begin
        fits = size_fits(w) && size_fits(h);
        px   = fits ? 10'($urandom_range(ScreenWidth - w)) : 10'($urandom);
        py   = fits ? 10'($urandom_range(ScreenHeight - h)) : 10'($urandom);
        send_item(OP_START, px, py, 8'($urandom), CHK_MODEL);
        n_items++;
        nbytes = fits ? ((w + 7) / 8) * h : $urandom_range(3, 1);
        if ($urandom_range(9) == 0) nbytes = $urandom_range(nbytes);
        cut = ($urandom_range(9) == 0) ? $urandom_range(nbytes) : -1;
        for (b = 0; b < nbytes; b++) begin
          if (b == cut) begin
            drain_link();
            if ($urandom_range(1) == 0) begin
              w = $urandom_range(16);
              write_size(CFG_GLYPH_WIDTH, w);
            end else begin
              h = $urandom_range(4);
              write_size(CFG_GLYPH_HEIGHT, h);
            end
          end
          send_item(OP_BITMAP, 10'($urandom), 10'($urandom), 8'($urandom), CHK_MODEL);
          n_items++;
        end
      end
    end
  endtask

  initial begin
    int ph;

    // Directed rows. The first few run under the register defaults.
    add_item(OP_BITMAP, 0, 0, 8'hA5, CHK_NONE);         // stray byte, nothing open
    add_item(OP_START, 0, 0, 0, CHK_HDR_ORIGIN);
    add_item(OP_BITMAP, 0, 0, 8'hFF, CHK_ALL_FG);
    add_item(OP_START, 232, 304, 0, CHK_MODEL);         // abandons the open glyph
    add_item(OP_BITMAP, 0, 0, 8'h81, CHK_MODEL);
    add_item(OP_START, 233, 0, 0, CHK_NONE);            // one column off screen
    add_item(OP_BITMAP, 0, 0, 8'h3C, CHK_NONE);         // stray after the rejection
    add_item(OP_START, 1023, 1023, 0, CHK_NONE);
    add_cfg(CFG_FG_COLOR, 16'h0000);
    add_cfg(CFG_BG_COLOR, 16'hFFFF);
    add_cfg(CFG_GLYPH_WIDTH, 16'd1);
    add_cfg(CFG_GLYPH_HEIGHT, 16'd1);
    add_item(OP_START, 239, 319, 0, CHK_MODEL);         // bottom-right pixel
    add_item(OP_BITMAP, 0, 0, 8'h80, CHK_MODEL);
    add_item(OP_BITMAP, 0, 0, 8'h7F, CHK_NONE);         // glyph already finished
    add_cfg(CFG_FG_COLOR, 16'hF81F);
    add_cfg(CFG_BG_COLOR, 16'h07E0);
    add_cfg(CFG_GLYPH_WIDTH, 16'd64);
    add_cfg(CFG_GLYPH_HEIGHT, 16'd64);
    add_cfg(CFG_SPARE, 16'hFFFF);                       // must leave every register alone
    add_item(OP_START, 176, 256, 0, CHK_MODEL);         // largest glyph, flush right and low
    add_item(OP_BITMAP, 0, 0, 8'hFF, CHK_MODEL);
    add_item(OP_BITMAP, 0, 0, 8'h00, CHK_MODEL);
    add_item(OP_BITMAP, 0, 0, 8'hA5, CHK_MODEL);
    add_item(OP_BITMAP, 0, 0, 8'h5A, CHK_MODEL);
    add_item(OP_START, 177, 256, 0, CHK_NONE);
    add_cfg(CFG_GLYPH_WIDTH, 16'd0);
    add_item(OP_START, 0, 0, 0, CHK_NONE);              // zero width rejects the start
    add_cfg(CFG_GLYPH_WIDTH, 16'd9);
    add_cfg(CFG_GLYPH_HEIGHT, 16'd2);
    add_item(OP_START, 10, 20, 0, CHK_MODEL);
    add_item(OP_BITMAP, 0, 0, 8'h5A, CHK_MODEL);
    // Narrowing in mid-row leaves the next byte wholly past the width: it
    // yields no pixels but still ends the row.
    add_cfg(CFG_GLYPH_WIDTH, 16'd8);
    add_item(OP_BITMAP, 0, 0, 8'hFF, CHK_MODEL);
    add_item(OP_BITMAP, 0, 0, 8'hC3, CHK_MODEL);
    add_item(OP_START, 0, 0, 0, CHK_MODEL);
    // An illegal width seen by a bitmap byte shuts the glyph.
    add_cfg(CFG_GLYPH_WIDTH, 16'hFF7F);
    add_item(OP_BITMAP, 0, 0, 8'h3C, CHK_NONE);
    add_cfg(CFG_GLYPH_WIDTH, 16'd8);
    add_item(OP_BITMAP, 0, 0, 8'h3C, CHK_NONE);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i]) run_row(directed_q[i]);

    // Random part: sender mostly busy and receiver often stalled, then the
    // reverse, then both flat out.
    for (ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 68;
        recv_idle_pct = 13;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_phase(22);
    end

    drain_link();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* glyph_bitmap_to_rgb565_stream.f */
design/gbr_pkg.sv
design/gbr_ctrl.sv
design/gbr_dp.sv
design/glyph_bitmap_to_rgb565_stream.sv
verif/tb_glyph_bitmap_to_rgb565_stream.sv
